// ===== design/kpc_pkg.sv =====
// kpc_pkg: shared constants and types for the key press classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_LONG_PRESS    = cfg_index_t'(0);
    localparam cfg_index_t REG_SHORT_CONFIRM = cfg_index_t'(1);

    localparam cfg_data_t LONG_PRESS_RESET    = cfg_data_t'(100);
    localparam cfg_data_t SHORT_CONFIRM_RESET = cfg_data_t'(30);

    typedef logic [1:0] phase_t;

    localparam phase_t PHASE_IDLE     = 2'd0;
    localparam phase_t PHASE_DEBOUNCE = 2'd1;
    localparam phase_t PHASE_PRESSED  = 2'd2;

endpackage

`default_nettype wire

// ===== design/kpc_key_if.sv =====
// kpc_key_if: request channel carrying one scan of raw key levels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface kpc_key_if #(
    parameter int NUM_KEYS = 4
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

`default_nettype wire

// ===== design/kpc_result_if.sv =====
// kpc_result_if: request channel carrying short and long press flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface kpc_result_if #(
    parameter int NUM_KEYS = 4
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] short_events;
    logic [NUM_KEYS-1:0] long_held;

    modport source (output valid, output short_events, output long_held, input ready);
    modport sink   (input valid, input short_events, input long_held, output ready);
endinterface

`default_nettype wire

// ===== design/kpc_cfg_if.sv =====
// kpc_cfg_if: register write channel, index and data
// depends on kpc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kpc_cfg_if;
    import kpc_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/key_press_classifier.sv =====
// key_press_classifier: per-key debounce with short and long press detection
// depends on kpc_pkg, kpc_key_if, kpc_result_if, kpc_cfg_if
//
// usage
//   keys    : one request per scan tick, bit i is the raw level of key i, 0 = pressed
//   results : one request per tick, short_events pulses when a short press is
//             confirmed, long_held is set on every held tick past the long threshold
//   cfg     : register writes, index 0 long press ticks, index 1 short confirm
//             ticks, always ready; write only while no tick is in flight
// timing
//   a tick is registered on acceptance, then classified and written to the
//   result register on the next edge: two cycles from request to result
//   one tick per cycle sustained; the per-key counters and phases update in
//   a single cycle, so nothing iterates
// reset
//   all keys idle, no window open, counters zero, registers at 100 and 30
// stall
//   while results is stalled the result register holds, the input register
//   fills, and keys then stays not ready until the result is taken
`timescale 1ns / 1ps
`default_nettype none

module key_press_classifier #(
    parameter int NUM_KEYS   = 4,
    parameter int COUNT_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    kpc_key_if.sink       keys,
    kpc_result_if.source  results,
    kpc_cfg_if.sink       cfg
);
    import kpc_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    cfg_data_t long_press_reg;
    cfg_data_t short_confirm_reg;

    logic                in_valid_reg;
    logic [NUM_KEYS-1:0] levels_reg;

    logic                out_valid_reg;
    logic [NUM_KEYS-1:0] short_reg;
    logic [NUM_KEYS-1:0] long_reg;

    phase_t              phase_reg  [NUM_KEYS];
    count_t              hold_reg   [NUM_KEYS];
    logic [NUM_KEYS-1:0] wopen_reg;
    count_t              wcount_reg [NUM_KEYS];

    phase_t              phase_next  [NUM_KEYS];
    count_t              hold_next   [NUM_KEYS];
    logic [NUM_KEYS-1:0] wopen_next;
    count_t              wcount_next [NUM_KEYS];
    logic [NUM_KEYS-1:0] short_next;
    logic [NUM_KEYS-1:0] long_next;

    logic advance;
    logic take_in;

    assign advance = in_valid_reg && (!out_valid_reg || results.ready);
    assign take_in = keys.valid && keys.ready;

    assign keys.ready           = !in_valid_reg || advance;
    assign cfg.ready            = 1'b1;
    assign results.valid        = out_valid_reg;
    assign results.short_events = short_reg;
    assign results.long_held    = long_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            phase_next[i]  = phase_reg[i];
            hold_next[i]   = hold_reg[i];
            wopen_next[i]  = wopen_reg[i];
            wcount_next[i] = wcount_reg[i];
            short_next[i]  = 1'b0;
            long_next[i]   = 1'b0;

            case (phase_reg[i])
                PHASE_DEBOUNCE:
                begin
                    phase_next[i] = !levels_reg[i] ? PHASE_PRESSED : PHASE_IDLE;
                end
                PHASE_PRESSED:
                begin
                    if (levels_reg[i])
                    begin
                        if (cmp_t'(hold_reg[i]) < cmp_t'(long_press_reg))
                        begin
                            if (!wopen_reg[i])
                            begin
                                wopen_next[i]  = 1'b1;
                                wcount_next[i] = '0;
                            end
                        end
                        else
                        begin
                            wopen_next[i] = 1'b0;
                        end
                        phase_next[i] = PHASE_IDLE;
                    end
                    else
                    begin
                        if (hold_reg[i] != COUNT_MAX)
                        begin
                            hold_next[i] = hold_reg[i] + count_t'(1);
                        end
                        long_next[i] = cmp_t'(hold_next[i]) >= cmp_t'(long_press_reg);
                    end
                end
                default:
                begin
                    // idle and the unused phase code
                    if (!levels_reg[i])
                    begin
                        phase_next[i] = PHASE_DEBOUNCE;
                        hold_next[i]  = '0;
                    end
                    else
                    begin
                        phase_next[i] = PHASE_IDLE;
                    end
                end
            endcase

            if (wopen_next[i])
            begin
                if (wcount_next[i] != COUNT_MAX)
                begin
                    wcount_next[i] = wcount_next[i] + count_t'(1);
                end
                if (cmp_t'(wcount_next[i]) >= cmp_t'(short_confirm_reg))
                begin
                    short_next[i] = 1'b1;
                    wopen_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= LONG_PRESS_RESET;
            short_confirm_reg <= SHORT_CONFIRM_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_LONG_PRESS)
            begin
                long_press_reg <= cfg.data;
            end
            else if (cfg.index == REG_SHORT_CONFIRM)
            begin
                short_confirm_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (keys.ready)
            begin
                in_valid_reg <= keys.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // key state moves on only when a tick is classified
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wopen_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                phase_reg[i]  <= PHASE_IDLE;
                hold_reg[i]   <= '0;
                wcount_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            wopen_reg <= wopen_next;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                phase_reg[i]  <= phase_next[i];
                hold_reg[i]   <= hold_next[i];
                wcount_reg[i] <= wcount_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            levels_reg <= keys.key_levels;
        end
        if (advance)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end

endmodule

`default_nettype wire
